// ----- hw/rtl/lrupr_pkg.sv -----
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int FRAMES  = 8;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int PAGE_W  = 16;
  localparam int NUM_W   = 4;
  localparam int FAULT_W = 16;
  localparam int FI_W    = 3;
  localparam int CMP_W   = (CNT_W > NUM_W) ? CNT_W : NUM_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_W   = PADDR_W - 2;

  localparam logic [REG_W-1:0] REG_NUM_FRAMES = REG_W'(0);
  localparam logic [NUM_W-1:0] NUM_FRAMES_RST = NUM_W'(8);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

endpackage

// ----- hw/rtl/lrupr_req_if.sv -----
`timescale 1ns / 1ps

interface lrupr_req_if;
  logic                          valid;
  logic                          ready;
  logic [lrupr_pkg::PAGE_W-1:0]  page;
  logic                          last_ref;

  modport source (output valid, page, last_ref, input ready);
  modport sink (input valid, page, last_ref, output ready);
endinterface

// ----- hw/rtl/lrupr_rsp_if.sv -----
`timescale 1ns / 1ps

interface lrupr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic                           fault;
  logic [lrupr_pkg::FI_W-1:0]     frame_index;
  logic                           evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]   evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]  fault_total;
  logic                           string_end;

  modport source (
    output valid, hit, fault, frame_index, evicted_valid, evicted_page, fault_total,
           string_end,
    input  ready
  );
  modport sink (
    input  valid, hit, fault, frame_index, evicted_valid, evicted_page, fault_total,
           string_end,
    output ready
  );
endinterface

// ----- hw/rtl/lrupr_frame_ram.sv -----
`timescale 1ns / 1ps

module lrupr_frame_ram (
  input  logic                clk_i,
  input  lrupr_pkg::ram_req_t req_i,
  output lrupr_pkg::entry_t   rd_data_o
);

  lrupr_pkg::entry_t mem_q [lrupr_pkg::FRAMES];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
`timescale 1ns / 1ps

// LRU page replacement over a fully associative frame store. Each accepted word
// is one page reference and yields exactly one result word: hit or fault, the
// frame now holding the page, the evicted page if any, and the saturating fault
// total of the current string. Pages and recency ranks live in a synchronous
// frame memory with one read port and one write port; valid bits, the fill
// count and the fault counter are flops. Each item makes two passes over the
// active frames: one pass reads every active frame to find the match and the
// oldest frame, a second pass reads, ages and writes back each frame, both at
// one frame per cycle through the memory port. A finished result sits in an
// output register, so the next reference is taken while it waits. num_frames
// is set over APB at byte address 0; 0 acts as 1 and values above the frame
// count act as the frame count. A reference flagged last_ref clears all string
// state after its result.

module lru_page_replacement (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lrupr_req_if.sink                           req_i,
  lrupr_rsp_if.source                         rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0]       paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0]       pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [lrupr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [lrupr_pkg::IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [lrupr_pkg::PAGE_W-1:0]  page_q;
  logic                          last_q;
  logic                          match_q, match_d;
  logic [lrupr_pkg::IDX_W-1:0]   match_idx_q, match_idx_d;
  logic [lrupr_pkg::RANK_W-1:0]  match_rank_q, match_rank_d;
  logic [lrupr_pkg::IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [lrupr_pkg::RANK_W-1:0]  best_rank_q, best_rank_d;
  logic [lrupr_pkg::PAGE_W-1:0]  best_page_q, best_page_d;
  logic [lrupr_pkg::FRAMES-1:0]  valid_q;
  logic [lrupr_pkg::CNT_W-1:0]   filled_q;
  logic [lrupr_pkg::FAULT_W-1:0] fault_q;
  logic [lrupr_pkg::NUM_W-1:0]   num_frames_q;

  logic                          res_valid_q;
  logic                          res_hit_q;
  logic [lrupr_pkg::FI_W-1:0]    res_fi_q;
  logic                          res_ev_q;
  logic [lrupr_pkg::PAGE_W-1:0]  res_evp_q;
  logic [lrupr_pkg::FAULT_W-1:0] res_ft_q;
  logic                          res_end_q;

  logic [lrupr_pkg::CMP_W-1:0]   num_ext;
  logic [lrupr_pkg::CNT_W-1:0]   act;
  logic                          issue;
  logic                          rd_valid_bit;
  logic                          miss;
  logic                          fill;
  logic                          evict;
  logic [lrupr_pkg::IDX_W-1:0]   sel_idx;
  logic [lrupr_pkg::RANK_W-1:0]  sel_rank;
  logic [lrupr_pkg::FAULT_W-1:0] fault_nxt;
  logic                          load;
  logic                          accept;
  logic                          cfg_sel;
  logic                          cfg_wr;

  lrupr_pkg::ram_req_t ram_req;
  lrupr_pkg::entry_t   rd_data;
  lrupr_pkg::entry_t   upd_entry;

  lrupr_frame_ram u_frame_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // active frame count with clamping
  assign num_ext = lrupr_pkg::CMP_W'(num_frames_q);
  always_comb begin
    priority if (num_frames_q == '0) begin
      act = lrupr_pkg::CNT_W'(1);
    end else if (num_ext > lrupr_pkg::CMP_W'(lrupr_pkg::FRAMES)) begin
      act = lrupr_pkg::CNT_W'(lrupr_pkg::FRAMES);
    end else begin
      act = lrupr_pkg::CNT_W'(num_ext);
    end
  end

  assign issue        = (cnt_q < act);
  assign rd_valid_bit = valid_q[rd_idx_q];
  assign miss         = !match_q;
  assign fill         = miss && (filled_q < act);
  assign evict        = miss && !fill;
  assign sel_idx      = match_q ? match_idx_q :
                        fill    ? filled_q[lrupr_pkg::IDX_W-1:0] : best_idx_q;
  assign sel_rank     = match_q ? match_rank_q : best_rank_q;
  assign fault_nxt    = !miss ? fault_q :
                        (fault_q == '1) ? fault_q : fault_q + lrupr_pkg::FAULT_W'(1);

  assign accept = req_i.valid && req_i.ready;
  assign load   = (state_q == S_DONE) && (!res_valid_q || rsp_o.ready);

  // aging of one frame in the write-back pass
  always_comb begin
    upd_entry = rd_data;
    if (rd_idx_q == sel_idx) begin
      upd_entry.rank = '0;
      if (miss) begin
        upd_entry.page = page_q;
      end
    end else if (rd_valid_bit) begin
      if (fill) begin
        if (rd_data.rank != '1) begin
          upd_entry.rank = rd_data.rank + lrupr_pkg::RANK_W'(1);
        end
      end else if (rd_data.rank < sel_rank) begin
        upd_entry.rank = rd_data.rank + lrupr_pkg::RANK_W'(1);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_rank_d = match_rank_q;
    best_idx_d   = best_idx_q;
    best_rank_d  = best_rank_q;
    best_page_d  = best_page_q;

    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = cnt_q[lrupr_pkg::IDX_W-1:0];
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = rd_idx_q;
    ram_req.wr_data = upd_entry;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d     = S_SCAN;
          cnt_d       = '0;
          match_d     = 1'b0;
          best_idx_d  = '0;
          best_rank_d = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          ram_req.rd_en = 1'b1;
          rd_vld_d      = 1'b1;
          rd_idx_d      = cnt_q[lrupr_pkg::IDX_W-1:0];
          cnt_d         = cnt_q + lrupr_pkg::CNT_W'(1);
        end else begin
          state_d = S_UPD;
          cnt_d   = '0;
        end
        if (rd_vld_q && rd_valid_bit) begin
          if (!match_q && (rd_data.page == page_q)) begin
            match_d      = 1'b1;
            match_idx_d  = rd_idx_q;
            match_rank_d = rd_data.rank;
          end
          if ((rd_data.rank > best_rank_q) || (rd_idx_q == '0)) begin
            best_idx_d  = rd_idx_q;
            best_rank_d = rd_data.rank;
            best_page_d = rd_data.page;
          end
        end
      end
      S_UPD: begin
        if (issue) begin
          ram_req.rd_en = 1'b1;
          rd_vld_d      = 1'b1;
          rd_idx_d      = cnt_q[lrupr_pkg::IDX_W-1:0];
          cnt_d         = cnt_q + lrupr_pkg::CNT_W'(1);
        end else begin
          state_d = S_DONE;
        end
        if (rd_vld_q) begin
          ram_req.wr_en = 1'b1;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      valid_q     <= '0;
      filled_q    <= '0;
      fault_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      match_q  <= match_d;
      if (load) begin
        res_valid_q <= 1'b1;
        if (last_q) begin
          valid_q  <= '0;
          filled_q <= '0;
          fault_q  <= '0;
        end else begin
          fault_q <= fault_nxt;
          if (miss) begin
            valid_q[sel_idx] <= 1'b1;
          end
          if (fill) begin
            filled_q <= filled_q + lrupr_pkg::CNT_W'(1);
          end
        end
      end else if (rsp_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    match_idx_q  <= match_idx_d;
    match_rank_q <= match_rank_d;
    best_idx_q   <= best_idx_d;
    best_rank_q  <= best_rank_d;
    best_page_q  <= best_page_d;
    if (accept) begin
      page_q <= req_i.page;
      last_q <= req_i.last_ref;
    end
    if (load) begin
      res_hit_q <= match_q;
      res_fi_q  <= lrupr_pkg::FI_W'(sel_idx);
      res_ev_q  <= evict;
      res_evp_q <= evict ? best_page_q : '0;
      res_ft_q  <= fault_nxt;
      res_end_q <= last_q;
    end
  end

  // configuration port
  assign cfg_sel = (paddr[lrupr_pkg::PADDR_W-1:2] == lrupr_pkg::REG_NUM_FRAMES);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? lrupr_pkg::PDATA_W'(num_frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= lrupr_pkg::NUM_FRAMES_RST;
    end else if (cfg_wr) begin
      num_frames_q <= pwdata[lrupr_pkg::NUM_W-1:0];
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = res_valid_q;
  assign rsp_o.hit           = res_hit_q;
  assign rsp_o.fault         = !res_hit_q;
  assign rsp_o.frame_index   = res_fi_q;
  assign rsp_o.evicted_valid = res_ev_q;
  assign rsp_o.evicted_page  = res_evp_q;
  assign rsp_o.fault_total   = res_ft_q;
  assign rsp_o.string_end    = res_end_q;

endmodule

// ----- hw/rtl/lrupr_checker.sv -----
`timescale 1ns / 1ps

module lrupr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           ready_i,
  input logic                           hit_i,
  input logic                           fault_i,
  input logic [lrupr_pkg::FI_W-1:0]     frame_index_i,
  input logic                           evicted_valid_i,
  input logic [lrupr_pkg::PAGE_W-1:0]   evicted_page_i,
  input logic [lrupr_pkg::FAULT_W-1:0]  fault_total_i,
  input logic                           string_end_i
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable({hit_i, fault_i, frame_index_i,
      evicted_valid_i, evicted_page_i, fault_total_i, string_end_i}))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (fault_i != hit_i))
    else $error("hit and fault not exclusive");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && evicted_valid_i |-> fault_i)
    else $error("eviction without fault");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !evicted_valid_i |-> (evicted_page_i == '0))
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (rsp_o.valid),
  .ready_i         (rsp_o.ready),
  .hit_i           (rsp_o.hit),
  .fault_i         (rsp_o.fault),
  .frame_index_i   (rsp_o.frame_index),
  .evicted_valid_i (rsp_o.evicted_valid),
  .evicted_page_i  (rsp_o.evicted_page),
  .fault_total_i   (rsp_o.fault_total),
  .string_end_i    (rsp_o.string_end)
);
